// ----- design/slw_pkg.sv -----
// Shared types and constants for the seven-segment line writer.
// Used by the front end, the command queue, the back end and the top level.
// No dependencies.
package slw_pkg;

	// Command codes on the input stream.
	localparam logic [1:0] OP_HEX16 = 2'd0;
	localparam logic [1:0] OP_DEC16 = 2'd1;
	localparam logic [1:0] OP_HEX8  = 2'd2;

	// Command kinds after classification.
	localparam logic [1:0] KIND_LINE = 2'd0;
	localparam logic [1:0] KIND_ERR  = 2'd1;
	localparam logic [1:0] KIND_HEX8 = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_NO_POINT = 2'd0;
	localparam logic [1:0] REG_LETTER_E = 2'd1;
	localparam logic [1:0] REG_LETTER_R = 2'd2;

	localparam logic [7:0] CTRL_DECODE     = 8'h58;
	localparam logic [7:0] CTRL_RAW        = 8'h78;
	localparam logic [7:0] BLANK_DATA      = 8'h80;
	localparam logic [7:0] NO_POINT_RESET  = 8'h80;
	localparam logic [15:0] DEC_LIMIT      = 16'd9999;

	// floor(n / 10) == (n * DIV10_RECIP) >> DIV10_SHIFT for every n below 10000.
	localparam logic [15:0] DIV10_RECIP = 16'd52429;
	localparam int          DIV10_SHIFT = 19;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [1:0]      kind;
		logic [2:0]      addr;    // line base for line kinds, high-nibble address for hex8
		logic [3:0][3:0] digits;  // digits[0] is the least significant digit
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

endpackage

// ----- design/seven_segment_line_writer_top.sv -----
// Top level of the seven-segment line writer.
// Depends on slw_pkg, slw_front, slw_queue and slw_back.
//
// One command enters on the s_axis channel, its op code in tuser; the byte
// pairs for the display controller leave on the m_axis channel, tlast marking
// the final pair of a command. Hex16 and in-range Dec16 commands give eight
// pairs, an out-of-range Dec16 gives seven, Hex8 gives two, and op code 3
// gives none.
// The back end sends one pair per cycle while m_axis_tready is high; a queued
// next command's pairs follow without a gap. From acceptance a command passes
// the front-end entry register, the queue, the back end's command register and
// its output register to its first pair, decimal ones after the digit-per-cycle
// front-end conversion. A two-entry queue lets the front end keep taking
// commands while the output is busy or stalled.
// The cfg port writes no_point_mask, letter_e_code and letter_r_code (index
// 0..2) and is meant to be used while the block is idle.
// Reset clears the queue and the output; the masks return to 0x80, 0, 0.
// When m_axis_tready is low the current pair holds and s_axis_tready drops
// once the queue and the front end are full.
module seven_segment_line_writer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // value[15:0], line[16], address[19:17]
	input  logic [1:0]  s_axis_tuser,  // op[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // control_byte[7:0], data_byte[15:8]
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_wdata
);

	slw_pkg::push_t  push;
	logic            push_ready;
	logic            pop_valid;
	slw_pkg::entry_t pop_entry;
	logic            pop;
	logic [7:0]      control_byte;
	logic [7:0]      data_byte;

	slw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.op         (s_axis_tuser),
		.value      (s_axis_tdata[15:0]),
		.line       (s_axis_tdata[16]),
		.address    (s_axis_tdata[19:17]),
		.push       (push),
		.push_ready (push_ready)
	);

	slw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry),
		.pop        (pop)
	);

	slw_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.pop_valid    (pop_valid),
		.pop_entry    (pop_entry),
		.pop          (pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.control_byte (control_byte),
		.data_byte    (data_byte),
		.last         (m_axis_tlast)
	);

	assign m_axis_tdata = {data_byte, control_byte};

endmodule

// ----- design/slw_front.sv -----
// Front end: accepts commands, classifies them and converts decimal values
// one digit per cycle. Depends on slw_pkg.
module slw_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      op,
	input  logic [15:0]     value,
	input  logic            line,
	input  logic [2:0]      address,
	output slw_pkg::push_t  push,
	input  logic            push_ready
);

	logic             busy_q;
	logic             conv_q;
	logic [1:0]       cnt_q;
	logic [13:0]      rem_q;
	slw_pkg::entry_t  ent_q;

	logic             do_push;
	logic             accept;
	logic [29:0]      prod;
	logic [9:0]       quot;
	logic [13:0]      diff;

	assign do_push  = busy_q && !conv_q && push_ready;
	assign in_ready = !busy_q || do_push;
	assign accept   = in_valid && in_ready;

	assign push.valid = busy_q && !conv_q;
	assign push.entry = ent_q;

	// Divide the remainder by ten through a reciprocal multiply.
	assign prod = 30'(rem_q) * 30'(slw_pkg::DIV10_RECIP);
	assign quot = prod[slw_pkg::DIV10_SHIFT +: 10];
	assign diff = rem_q - ({4'b0, quot} << 3) - ({4'b0, quot} << 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			conv_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else if (accept) begin
			busy_q <= (op == slw_pkg::OP_HEX16) || (op == slw_pkg::OP_DEC16) ||
				(op == slw_pkg::OP_HEX8);
			conv_q <= (op == slw_pkg::OP_DEC16) && (value <= slw_pkg::DEC_LIMIT);
			cnt_q  <= 2'd0;
		end else if (conv_q) begin
			cnt_q <= cnt_q + 2'd1;
			if (cnt_q == 2'd3) begin
				conv_q <= 1'b0;
			end
		end else if (do_push) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rem_q        <= value[13:0];
			ent_q.digits <= value;
			unique case (op)
				slw_pkg::OP_HEX8: begin
					ent_q.kind <= slw_pkg::KIND_HEX8;
					ent_q.addr <= address;
				end
				slw_pkg::OP_DEC16: begin
					ent_q.kind <= (value > slw_pkg::DEC_LIMIT) ? slw_pkg::KIND_ERR
						: slw_pkg::KIND_LINE;
					ent_q.addr <= {line, 2'b00};
				end
				default: begin
					ent_q.kind <= slw_pkg::KIND_LINE;
					ent_q.addr <= {line, 2'b00};
				end
			endcase
		end else if (conv_q) begin
			ent_q.digits[cnt_q] <= diff[3:0];
			rem_q               <= {4'b0, quot};
		end
	end

endmodule

// ----- design/slw_queue.sv -----
// Short command queue between the front end and the back end.
// Depends on slw_pkg.
module slw_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  slw_pkg::push_t   push,
	output logic             push_ready,
	output logic             pop_valid,
	output slw_pkg::entry_t  pop_entry,
	input  logic             pop
);

	localparam int PtrW = (slw_pkg::QUEUE_DEPTH > 1) ? $clog2(slw_pkg::QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(slw_pkg::QUEUE_DEPTH + 1);

	slw_pkg::entry_t mem_q [slw_pkg::QUEUE_DEPTH];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [CntW-1:0] cnt_q;
	logic            wr_en;
	logic            rd_en;

	assign push_ready = (cnt_q != CntW'(slw_pkg::QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_entry  = mem_q[rd_q];
	assign wr_en      = push.valid && push_ready;
	assign rd_en      = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= (wr_q == PtrW'(slw_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (rd_en) begin
				rd_q <= (rd_q == PtrW'(slw_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CntW'(wr_en) - CntW'(rd_en);
		end
	end

endmodule

// ----- design/slw_back.sv -----
// Back end: holds the configuration registers and expands each queued
// command into its byte pairs, one pair per cycle unless out_ready stalls it. Depends on slw_pkg.
module slw_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [7:0]       cfg_wdata,
	input  logic             pop_valid,
	input  slw_pkg::entry_t  pop_entry,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       control_byte,
	output logic [7:0]       data_byte,
	output logic             last
);

	logic [7:0]       no_point_q;
	logic [7:0]       letter_e_q;
	logic [7:0]       letter_r_q;

	logic             active_q;
	logic [2:0]       step_q;
	slw_pkg::entry_t  cur_q;
	logic             valid_q;
	logic [7:0]       ctrl_q;
	logic [7:0]       data_q;
	logic             last_q;

	logic             adv;
	logic             raw;
	logic [2:0]       addr;
	logic [7:0]       data;
	logic             is_last;
	logic [3:0]       nib;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			no_point_q <= slw_pkg::NO_POINT_RESET;
			letter_e_q <= 8'h00;
			letter_r_q <= 8'h00;
		end else if (cfg_we) begin
			case (cfg_index)
				slw_pkg::REG_NO_POINT: no_point_q <= cfg_wdata;
				slw_pkg::REG_LETTER_E: letter_e_q <= cfg_wdata;
				slw_pkg::REG_LETTER_R: letter_r_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Pair for the current step of the current command.
	always_comb begin
		raw     = 1'b1;
		addr    = cur_q.addr | {1'b0, step_q[1:0]};
		nib     = cur_q.digits[step_q[1:0]];
		data    = slw_pkg::BLANK_DATA;
		is_last = 1'b0;
		unique case (cur_q.kind)
			slw_pkg::KIND_HEX8: begin
				raw     = 1'b0;
				nib     = cur_q.digits[{1'b0, step_q[0]}];
				addr    = step_q[0] ? cur_q.addr : cur_q.addr + 3'd1;
				data    = {4'b0, nib} | no_point_q;
				is_last = step_q[0];
			end
			slw_pkg::KIND_ERR: begin
				if (step_q[2]) begin
					data = (step_q[1:0] == 2'd0) ? letter_e_q : letter_r_q;
				end
				is_last = (step_q == 3'd6);
			end
			default: begin
				if (step_q[2]) begin
					// Digits go out lowest first, from line position 3 down to 0.
					raw  = 1'b0;
					addr = cur_q.addr | {1'b0, ~step_q[1:0]};
					data = {4'b0, nib} | no_point_q;
				end
				is_last = (step_q == 3'd7);
			end
		endcase
	end

	assign adv = !valid_q || out_ready;
	assign pop = pop_valid && (!active_q || (adv && is_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			step_q   <= 3'd0;
			valid_q  <= 1'b0;
		end else begin
			if (adv) begin
				valid_q <= active_q;
			end
			if (pop) begin
				active_q <= 1'b1;
				step_q   <= 3'd0;
			end else if (adv && active_q) begin
				step_q <= step_q + 3'd1;
				if (is_last) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_entry;
		end
		if (adv && active_q) begin
			ctrl_q <= (raw ? slw_pkg::CTRL_RAW : slw_pkg::CTRL_DECODE) | {5'b0, addr};
			data_q <= data;
			last_q <= is_last;
		end
	end

	assign out_valid    = valid_q;
	assign control_byte = ctrl_q;
	assign data_byte    = data_q;
	assign last         = last_q;

endmodule

// ----- design/slw_checker.sv -----
// Port-level checks for the seven-segment line writer, bound to the top level.
// Depends on seven_segment_line_writer_top.
module slw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	// A stalled transaction stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output valid dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output payload changed while stalled");

	// Every control byte is a decoded or a raw write.
	a_ctrl_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[7:3] == 5'b01011) || (m_axis_tdata[7:3] == 5'b01111))
		else $error("control byte is neither a decoded nor a raw write");

	// Only the error message ends on a raw write, and it ends at line position 2.
	a_err_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast && m_axis_tdata[5] |-> m_axis_tdata[1:0] == 2'd2)
		else $error("raw write closes a transaction at the wrong position");

endmodule

bind seven_segment_line_writer_top slw_checker u_slw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
